[design/lfba_pkg.sv]
// ----------------------------------------------------------------------------
// lfba_pkg: shared types and constants of the LED frame brightness animator
// Widths, register indexes, animation modes, the pipeline stage record and
// the constant division by the triangle peak.
// ----------------------------------------------------------------------------
package lfba_pkg;

    // frame geometry
    localparam int unsigned LEN_W           = 13;
    localparam int unsigned POS_W           = 12;
    localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 13'd4096;
    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 13'd8;
    localparam logic [LEN_W-1:0] TAIL_SPAN      = 13'd7;
    localparam logic [POS_W-1:0] EDGE_BYTES     = 12'd4;

    // animation constants
    localparam logic [5:0] PHASE_LAST  = 6'd61;
    localparam logic [5:0] PHASE_STEPS = 6'd62;
    localparam logic [5:0] TRI_PEAK    = 6'd31;
    localparam logic [2:0] HEADER_BITS = 3'b111;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 2'd1;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_FADE  = 2'd2,
        MODE_PULSE = 2'd3
    } effect_t;

    // record held between the accept stage and the output register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       bright_slot;
        logic       need_div;
        logic [9:0] level;
        logic       frame_end;
    } s1_t;

    // floor(p / 31) for p up to 961 by reciprocal multiply
    function automatic logic [4:0] div31(input logic [9:0] p);
        logic [19:0] t;
        t = ({10'd0, p} + 20'd1) * 20'd1057;
        return t[19:15];
    endfunction

endpackage

[design/lfba_in_if.sv]
// ----------------------------------------------------------------------------
// lfba_in_if: base frame byte channel
// One base frame byte per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfba_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

[design/lfba_out_if.sv]
// ----------------------------------------------------------------------------
// lfba_out_if: animated frame byte channel
// One animated byte per beat with a last-byte-of-frame flag.
// ----------------------------------------------------------------------------
interface lfba_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, output out_byte, output frame_end, input ready);
    modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

[design/lfba_cfg_if.sv]
// ----------------------------------------------------------------------------
// lfba_cfg_if: configuration write channel
// Register index and write data per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lfba_pkg::CFG_INDEX_W-1:0] index;
    logic [lfba_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/lfba_front.sv]
// ----------------------------------------------------------------------------
// lfba_front: accept stage of the animator
// Holds the configuration, byte position, step phase and blink toggle,
// classifies each accepted byte and registers it with its raw brightness
// level (scaled by the triangle in fade modes).
// ----------------------------------------------------------------------------
module lfba_front (
    input  logic                clk,
    input  logic                rst_n,
    lfba_in_if.sink             frame,
    lfba_cfg_if.sink            cfg,
    input  logic                s2_take,
    output lfba_pkg::s1_t       s1,
    output logic                s1_valid
);

    lfba_pkg::effect_t                 mode_reg, mode_next;
    logic [lfba_pkg::LEN_W-1:0]        length_reg, length_next;
    logic [lfba_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [5:0]                        phase_reg, phase_next;
    logic                              blink_reg, blink_next;
    logic                              s1_valid_reg, s1_valid_next;
    lfba_pkg::s1_t                     s1_reg, s1_next;

    logic                              s1_take;
    logic                              accept;
    logic                              long_enough;
    logic [lfba_pkg::LEN_W-1:0]        eff_len;
    logic [lfba_pkg::LEN_W-1:0]        pos_ext;
    logic                              last;
    logic                              slot;
    logic [4:0]                        base;
    logic [4:0]                        tri_val;

    assign s1_take     = !s1_valid_reg || s2_take;
    assign frame.ready = s1_take;
    assign cfg.ready   = 1'b1;
    assign accept      = frame.valid && s1_take;

    // effective length and byte classification
    assign eff_len     = (length_reg > lfba_pkg::MAX_FRAME_BYTES) ?
                         lfba_pkg::MAX_FRAME_BYTES : length_reg;
    assign long_enough = eff_len >= lfba_pkg::MIN_FRAME_BYTES;
    assign pos_ext     = {1'b0, pos_reg};
    assign last        = pos_ext >= (eff_len - 13'd1);
    assign slot        = (pos_reg >= lfba_pkg::EDGE_BYTES) && (pos_reg[1:0] == 2'b00) &&
                         ((pos_ext + lfba_pkg::TAIL_SPAN) < eff_len);
    assign base        = frame.data_byte[4:0];
    assign tri_val     = (phase_reg < lfba_pkg::TRI_PEAK) ? phase_reg[4:0] :
                         5'(lfba_pkg::PHASE_STEPS - phase_reg);

    // stage record
    always_comb
    begin
        s1_next.data_byte   = frame.data_byte;
        s1_next.bright_slot = slot;
        s1_next.frame_end   = last;
        s1_next.need_div    = 1'b0;
        s1_next.level       = {5'd0, base};
        case (mode_reg)
            lfba_pkg::MODE_NONE:
            begin
                s1_next.level = {5'd0, base};
            end
            lfba_pkg::MODE_BLINK:
            begin
                s1_next.level = blink_reg ? {5'd0, base} : 10'd0;
            end
            lfba_pkg::MODE_FADE, lfba_pkg::MODE_PULSE:
            begin
                s1_next.need_div = 1'b1;
                s1_next.level    = {5'd0, base} * {5'd0, tri_val};
            end
            default:
            begin
                s1_next.level = {5'd0, base};
            end
        endcase
    end

    // configuration and animation state
    always_comb
    begin
        mode_next     = mode_reg;
        length_next   = length_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        blink_next    = blink_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_take)
        begin
            s1_valid_next = accept && long_enough;
        end
        if (accept && long_enough)
        begin
            if (last)
            begin
                pos_next   = '0;
                phase_next = (phase_reg == lfba_pkg::PHASE_LAST) ? 6'd0 : phase_reg + 6'd1;
                blink_next = !blink_reg;
            end
            else
            begin
                pos_next = pos_reg + 12'd1;
            end
        end
        if (cfg.valid)
        begin
            if (cfg.index == lfba_pkg::REG_EFFECT)
            begin
                mode_next  = lfba_pkg::effect_t'(cfg.data[1:0]);
                pos_next   = '0;
                phase_next = '0;
                blink_next = 1'b0;
            end
            else if (cfg.index == lfba_pkg::REG_FRAME_LENGTH)
            begin
                length_next = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= lfba_pkg::MODE_NONE;
            length_reg   <= '0;
            pos_reg      <= '0;
            phase_reg    <= '0;
            blink_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            length_reg   <= length_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            blink_reg    <= blink_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1       = s1_reg;
    assign s1_valid = s1_valid_reg;

endmodule

[design/lfba_back.sv]
// ----------------------------------------------------------------------------
// lfba_back: brightness finish and output register
// Divides the scaled level by the triangle peak where needed, builds the
// brightness byte and holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module lfba_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lfba_pkg::s1_t   s1,
    input  logic            s1_valid,
    output logic            s2_take,
    lfba_out_if.source      anim
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       frame_end_reg, frame_end_next;
    logic [4:0] bright;

    assign s2_take = !out_valid_reg || anim.ready;

    // final brightness and byte
    always_comb
    begin
        bright         = s1.need_div ? lfba_pkg::div31(s1.level) : s1.level[4:0];
        out_byte_next  = s1.bright_slot ? {lfba_pkg::HEADER_BITS, bright} : s1.data_byte;
        frame_end_next = s1.frame_end;
        out_valid_next = s2_take ? s1_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s1_valid)
        begin
            out_byte_reg  <= out_byte_next;
            frame_end_reg <= frame_end_next;
        end
    end

    assign anim.valid     = out_valid_reg;
    assign anim.out_byte  = out_byte_reg;
    assign anim.frame_end = frame_end_reg;

endmodule

[design/led_frame_brightness_animator_core.sv]
// ----------------------------------------------------------------------------
// led_frame_brightness_animator_core: LED frame brightness animator
// Rewrites the brightness byte of each LED slot in a streamed strip frame
// according to the animation mode; other bytes pass unchanged.
// ----------------------------------------------------------------------------
//  channel  role    beat contents
//  frame    sink    data_byte (8)
//  anim     source  out_byte (8), frame_end (1)
//  cfg      sink    index (2), data (13); 0 mode select, 1 frame_length
//
//  one byte per cycle sustained while anim is ready; a byte passes the accept
//  register, then the output register, before it shows on anim
//  bytes taken while frame_length is below 8 give no beat
//  a stall on anim holds the output register and frame.ready falls only
//  when both registers are full
//  reset clears configuration, position, phase, toggle and valid flags
// ----------------------------------------------------------------------------
module led_frame_brightness_animator_core (
    input  logic        clk,
    input  logic        rst_n,
    lfba_in_if.sink     frame,
    lfba_out_if.source  anim,
    lfba_cfg_if.sink    cfg
);

    lfba_pkg::s1_t s1;
    logic          s1_valid;
    logic          s2_take;

    // accept stage with animation state
    lfba_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .cfg      (cfg),
        .s2_take  (s2_take),
        .s1       (s1),
        .s1_valid (s1_valid)
    );

    // brightness finish and output register
    lfba_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1       (s1),
        .s1_valid (s1_valid),
        .s2_take  (s2_take),
        .anim     (anim)
    );

endmodule

[design/lfba_checker.sv]
// ----------------------------------------------------------------------------
// lfba_checker: port level checks of the animator
// Watches the top level ports for output hold and flow control behavior.
// ----------------------------------------------------------------------------
module lfba_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       frame_ready,
    input logic       anim_valid,
    input logic       anim_ready,
    input logic [7:0] anim_out_byte,
    input logic       anim_frame_end
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        anim_valid && !anim_ready |=>
            anim_valid && $stable(anim_out_byte) && $stable(anim_frame_end))
        else $error("lfba: stalled output beat changed");

    // empty output register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !anim_valid |-> frame_ready)
        else $error("lfba: input blocked with empty output");

    // a taken output frees the input side in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        anim_ready |-> frame_ready)
        else $error("lfba: input blocked while output drains");

endmodule

bind led_frame_brightness_animator_core lfba_checker u_lfba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_ready    (frame.ready),
    .anim_valid     (anim.valid),
    .anim_ready     (anim.ready),
    .anim_out_byte  (anim.out_byte),
    .anim_frame_end (anim.frame_end)
);

[test/led_frame_brightness_animator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_frame_brightness_animator_core_tb: self-checking bench for the animator
// Walks a short table of directed frame bytes and register writes, then
// streams random frames in pulse and random modes with random stalls on both
// channels. Every animated beat is checked against a table value or an in-bench
// model of the brightness rewrite, the phase counter and the blink toggle.
// ----------------------------------------------------------------------------
module led_frame_brightness_animator_core_tb;

    // register indexes outside the list, written to show they do nothing
    localparam logic [lfba_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [lfba_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned IDLE_PCT     = 16;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned SWEEP_FRAMES = 63;
    localparam int unsigned RANDOM_BYTES = 64;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_VALUE, CHK_NONE} row_check_t;

    typedef struct packed {
        row_kind_t                            kind;
        logic [lfba_pkg::CFG_INDEX_W-1:0]     index;
        logic [lfba_pkg::CFG_DATA_W-1:0]      data;
        row_check_t                           check;
        logic [7:0]                           out_byte;
        logic                                 frame_end;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } anim_beat_t;

    logic clk;
    logic rst_n;

    lfba_in_if  frame_if ();
    lfba_out_if anim_if ();
    lfba_cfg_if cfg_if ();

    led_frame_brightness_animator_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_if),
        .anim  (anim_if),
        .cfg   (cfg_if)
    );

    // model state of the animator
    lfba_pkg::effect_t          pred_mode;
    logic [lfba_pkg::LEN_W-1:0] pred_len;
    logic [lfba_pkg::POS_W-1:0] pred_pos;
    logic [5:0]                 pred_phase;
    logic                       pred_blink;

    anim_beat_t  pending_anim[$];
    dir_row_t    dir_rows[$];
    bit          idle_on = 1'b1;
    bit          bytes_since_drain = 1'b0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned frame_ends = 0;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // frame length with the oversize clamp applied
    function automatic int unsigned eff_len();
        return (pred_len > lfba_pkg::MAX_FRAME_BYTES) ?
               int'(lfba_pkg::MAX_FRAME_BYTES) : int'(pred_len);
    endfunction

    // random byte, biased toward brightness extremes
    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        if ($urandom_range(99) < 20)
        begin
            case ($urandom_range(3))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h1F;
                default: b = 8'hE0;
            endcase
        end
        else
        begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic dir_row_t cfg_row(input logic [lfba_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [lfba_pkg::CFG_DATA_W-1:0] value);
        dir_row_t r;
        r = '0;
        r.kind  = ROW_CFG;
        r.index = idx;
        r.data  = value;
        r.check = CHK_NONE;
        return r;
    endfunction

    function automatic dir_row_t byte_row(input logic [7:0] b, input row_check_t chk,
                                          input logic [7:0] ob, input logic fe);
        dir_row_t r;
        r = '0;
        r.kind      = ROW_BYTE;
        r.data      = {5'd0, b};
        r.check     = chk;
        r.out_byte  = ob;
        r.frame_end = fe;
        return r;
    endfunction

    // register write applied to the model
    task automatic apply_cfg(input logic [lfba_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lfba_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            lfba_pkg::REG_EFFECT:
            begin
                pred_mode  = lfba_pkg::effect_t'(value[1:0]);
                pred_phase = '0;
                pred_blink = 1'b0;
                pred_pos   = '0;
            end
            lfba_pkg::REG_FRAME_LENGTH: pred_len = value;
            default: ;
        endcase
    endtask

    // animated byte for one accepted frame byte; advances position and phase
    task automatic animate_byte(input logic [7:0] b, output bit got, output anim_beat_t beat);
        int unsigned len;
        int unsigned pos;
        int unsigned tri_lvl;
        logic [4:0]  lvl;
        bit          last;
        len = eff_len();
        pos = pred_pos;
        got = 1'b0;
        beat.out_byte  = b;
        beat.frame_end = 1'b0;
        if (len < lfba_pkg::MIN_FRAME_BYTES)
            return;
        got = 1'b1;
        // brightness byte of a slot clear of the end frame
        if (pos >= lfba_pkg::EDGE_BYTES && pos % 4 == 0 &&
            pos + 3 + lfba_pkg::EDGE_BYTES < len)
        begin
            case (pred_mode)
                lfba_pkg::MODE_BLINK: lvl = pred_blink ? b[4:0] : 5'd0;
                lfba_pkg::MODE_FADE, lfba_pkg::MODE_PULSE:
                begin
                    tri_lvl = (pred_phase < lfba_pkg::TRI_PEAK) ? pred_phase :
                              lfba_pkg::PHASE_STEPS - pred_phase;
                    lvl = 5'((b[4:0] * tri_lvl) / lfba_pkg::TRI_PEAK);
                end
                default: lvl = b[4:0];
            endcase
            beat.out_byte = {lfba_pkg::HEADER_BITS, lvl};
        end
        // last byte, including a length lowered below the position
        last = (pos >= len - 1);
        if (last)
        begin
            pred_pos   = '0;
            pred_phase = (pred_phase == lfba_pkg::PHASE_LAST) ? 6'd0 : pred_phase + 6'd1;
            pred_blink = ~pred_blink;
        end
        else
        begin
            pred_pos = lfba_pkg::POS_W'(pos + 1);
        end
        beat.frame_end = last;
    endtask

    // one register write beat; valid stays up until the next driven beat
    task automatic write_reg(input logic [lfba_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lfba_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        apply_cfg(idx, value);
        reg_writes++;
    endtask

    // one frame byte beat with random gaps in front
    task automatic drive_byte(input logic [7:0] b, input row_check_t chk,
                              input anim_beat_t typed);
        bit         got;
        anim_beat_t beat;
        cfg_if.valid <= 1'b0;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            frame_if.valid <= 1'b0;
            @(posedge clk);
        end
        frame_if.valid     <= 1'b1;
        frame_if.data_byte <= b;
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
        animate_byte(b, got, beat);
        bytes_sent++;
        bytes_since_drain = 1'b1;
        case (chk)
            CHK_VALUE:
            begin
                pending_anim.push_back(typed);
            end
            CHK_MODEL:
            begin
                if (got)
                begin
                    pending_anim.push_back(beat);
                end
            end
            default: ;
        endcase
    endtask

    // hold the sender until every expected beat is out and the pipe is empty
    task automatic drain_block();
        if (bytes_since_drain)
        begin
            frame_if.valid <= 1'b0;
            while (pending_anim.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            bytes_since_drain = 1'b0;
        end
    endtask

    // receiver: random stalls and beat check
    always @(posedge clk)
    begin
        anim_beat_t want;
        if (!rst_n)
        begin
            anim_if.ready <= 1'b0;
        end
        else
        begin
            anim_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            if (anim_if.valid && anim_if.ready)
            begin
                if (pending_anim.size() == 0)
                begin
                    $error("unexpected anim beat: out_byte=%02h frame_end=%0b",
                           anim_if.out_byte, anim_if.frame_end);
                    err_count++;
                end
                else
                begin
                    want = pending_anim.pop_front();
                    if (anim_if.out_byte !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, anim_if.out_byte);
                        err_count++;
                    end
                    if (anim_if.frame_end !== want.frame_end)
                    begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               want.frame_end, anim_if.frame_end);
                        err_count++;
                    end
                    beats_checked++;
                    if (want.frame_end)
                        frame_ends++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL led_frame_brightness_animator_core");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int unsigned                n;
        int unsigned                rem;
        int unsigned                sel;
        int unsigned                random_base;
        logic [lfba_pkg::LEN_W-1:0] lv;
        anim_beat_t                 typed;
        dir_row_t                   row;

        frame_if.valid     <= 1'b0;
        frame_if.data_byte <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        rst_n              <= 1'b0;
        typed = '0;

        pred_mode  = lfba_pkg::MODE_NONE;
        pred_len   = '0;
        pred_pos   = '0;
        pred_phase = '0;
        pred_blink = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short frames after reset and below the minimum: dropped
        dir_rows.push_back(byte_row(8'hA5, CHK_NONE, 8'h00, 1'b0));
        dir_rows.push_back(cfg_row(lfba_pkg::REG_FRAME_LENGTH, 13'd7));
        dir_rows.push_back(byte_row(8'h5A, CHK_NONE, 8'h00, 1'b0));
        // writes outside the register list
        dir_rows.push_back(cfg_row(REG_SPARE_2, 13'h1FFF));
        dir_rows.push_back(cfg_row(REG_SPARE_3, 13'h0000));
        // one-slot frame, mode none
        dir_rows.push_back(cfg_row(lfba_pkg::REG_FRAME_LENGTH, 13'd12));
        dir_rows.push_back(byte_row(8'h00, CHK_VALUE, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'hFF, CHK_VALUE, 8'hFF, 1'b0));
        dir_rows.push_back(byte_row(8'h00, CHK_VALUE, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'hFF, CHK_VALUE, 8'hFF, 1'b0));
        dir_rows.push_back(byte_row(8'h0A, CHK_VALUE, 8'hEA, 1'b0));
        dir_rows.push_back(byte_row(8'hFF, CHK_VALUE, 8'hFF, 1'b0));
        dir_rows.push_back(byte_row(8'h00, CHK_VALUE, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'h80, CHK_VALUE, 8'h80, 1'b0));
        dir_rows.push_back(byte_row(8'hFF, CHK_VALUE, 8'hFF, 1'b0));
        dir_rows.push_back(byte_row(8'h1F, CHK_VALUE, 8'h1F, 1'b0));
        dir_rows.push_back(byte_row(8'hE0, CHK_VALUE, 8'hE0, 1'b0));
        dir_rows.push_back(byte_row(8'h01, CHK_VALUE, 8'h01, 1'b1));
        // blink with an oversized length, then the length lowered mid-frame
        dir_rows.push_back(cfg_row(lfba_pkg::REG_EFFECT, {11'd0, lfba_pkg::MODE_BLINK}));
        dir_rows.push_back(cfg_row(lfba_pkg::REG_FRAME_LENGTH, 13'h1FFF));
        repeat (4) dir_rows.push_back(byte_row(8'h00, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'h1F, CHK_VALUE, 8'hE0, 1'b0));
        dir_rows.push_back(byte_row(8'h9F, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'h7E, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'hFF, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'h3F, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(cfg_row(lfba_pkg::REG_FRAME_LENGTH, 13'd8));
        dir_rows.push_back(byte_row(8'h77, CHK_VALUE, 8'h77, 1'b1));
        // fade at phase zero
        dir_rows.push_back(cfg_row(lfba_pkg::REG_EFFECT, {11'd0, lfba_pkg::MODE_FADE}));
        dir_rows.push_back(cfg_row(lfba_pkg::REG_FRAME_LENGTH, 13'd12));
        dir_rows.push_back(byte_row(8'h11, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'h22, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'h33, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'h44, CHK_MODEL, 8'h00, 1'b0));
        dir_rows.push_back(byte_row(8'hFF, CHK_VALUE, 8'hE0, 1'b0));

        // directed table
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain_block();
                write_reg(row.index, row.data);
            end
            else
            begin
                typed.out_byte  = row.out_byte;
                typed.frame_end = row.frame_end;
                drive_byte(row.data[7:0], row.check, typed);
            end
        end

        // full triangle sweep and phase wrap, no stalls on either side
        drain_block();
        write_reg(lfba_pkg::REG_EFFECT, {11'd0, lfba_pkg::MODE_PULSE});
        write_reg(lfba_pkg::REG_FRAME_LENGTH, 13'd12);
        idle_on = 1'b0;
        repeat (SWEEP_FRAMES * 12) drive_byte(rand_byte(), CHK_MODEL, typed);
        idle_on = 1'b1;

        random_base = bytes_sent;

        // random phases: mode and length changes between bursts
        while (bytes_sent - random_base < RANDOM_BYTES)
        begin
            drain_block();
            if ($urandom_range(99) < 25)
            begin
                lv = lfba_pkg::LEN_W'($urandom_range(3));
                write_reg(lfba_pkg::REG_EFFECT, lv);
            end
            if ($urandom_range(99) < 80)
            begin
                sel = $urandom_range(99);
                if (sel < 10)
                    lv = lfba_pkg::LEN_W'($urandom_range(7));
                else if (sel < 80)
                    lv = lfba_pkg::LEN_W'($urandom_range(24, 8));
                else if (sel < 95)
                    lv = lfba_pkg::LEN_W'($urandom_range(80, 25));
                else
                    lv = lfba_pkg::LEN_W'($urandom_range(8191, 4096));
                write_reg(lfba_pkg::REG_FRAME_LENGTH, lv);
            end
            if ($urandom_range(99) < 10)
            begin
                lv = lfba_pkg::LEN_W'($urandom);
                write_reg($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2, lv);
            end
            // burst length: noise, whole frames, or a partial frame
            if (eff_len() < lfba_pkg::MIN_FRAME_BYTES)
            begin
                n = $urandom_range(6, 1);
            end
            else if (eff_len() <= 80 && $urandom_range(1))
            begin
                rem = (pred_pos >= eff_len()) ? 1 : eff_len() - pred_pos;
                n = rem + $urandom_range(1) * eff_len();
            end
            else
            begin
                n = $urandom_range(40, 1);
            end
            repeat (n) drive_byte(rand_byte(), CHK_MODEL, typed);
        end

        drain_block();
        if (pending_anim.size() != 0)
        begin
            $error("pending anim beats left at end: %0d", pending_anim.size());
            err_count++;
        end

        $display("run: %0d frame bytes sent, %0d anim beats checked, %0d frame ends",
                 bytes_sent, beats_checked, frame_ends);
        $display("run: %0d register writes over all modes, lengths 0 to 8191, %0d errors",
                 reg_writes, err_count);
        if (err_count == 0)
            $display("PASS led_frame_brightness_animator_core");
        else
            $display("FAIL led_frame_brightness_animator_core");
        $finish;
    end

endmodule

[filelist.f]
design/lfba_pkg.sv
design/lfba_in_if.sv
design/lfba_out_if.sv
design/lfba_cfg_if.sv
design/lfba_front.sv
design/lfba_back.sv
design/led_frame_brightness_animator_core.sv
design/lfba_checker.sv
test/led_frame_brightness_animator_core_tb.sv
